// ===== rtl/dual_pedal_sensor_plausibility_core_defines.svh =====
// assertion macros for the pedal plausibility core
`ifndef DUAL_PEDAL_SENSOR_PLAUSIBILITY_CORE_DEFINES_SVH
`define DUAL_PEDAL_SENSOR_PLAUSIBILITY_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define DPSP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dpsp assertion failed");

// next-cycle implication, disabled during reset
`define DPSP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dpsp assertion failed");

`endif

// ===== rtl/dpsp_pkg.sv =====
// ---------------------------------------------------------------------------
// dpsp_pkg
// shared constants and types of the pedal plausibility core
// ---------------------------------------------------------------------------
package dpsp_pkg;

   localparam int REG_W   = 12;
   localparam int IDX_W   = 3;
   localparam int MV_W    = 12;
   localparam int POS_W   = 14;
   localparam int CAL_X_W = 24;

   localparam int unsigned SUPPLY_MV     = 3000;
   localparam int unsigned RANGE_LOW_MV  = 700;
   localparam int unsigned RANGE_HIGH_MV = 2700;
   localparam int unsigned FULL_TRAVEL   = 10000;
   localparam int unsigned MAX_DISAGREE  = 1000;

   localparam logic [IDX_W-1:0] REG_REF_CAL     = 3'd0;
   localparam logic [IDX_W-1:0] REG_FIRST_LOW   = 3'd1;
   localparam logic [IDX_W-1:0] REG_FIRST_HIGH  = 3'd2;
   localparam logic [IDX_W-1:0] REG_SECOND_LOW  = 3'd3;
   localparam logic [IDX_W-1:0] REG_SECOND_HIGH = 3'd4;

   localparam logic [REG_W-1:0] RST_REF_CAL   = 12'd1655;
   localparam logic [REG_W-1:0] RST_SPAN_LOW  = 12'd700;
   localparam logic [REG_W-1:0] RST_SPAN_HIGH = 12'd2700;

   typedef struct packed {
      logic [REG_W-1:0] low;
      logic [REG_W-1:0] high;
   } span_cfg_type;

   typedef struct packed {
      logic             bad;
      logic [POS_W-1:0] pos;
   } lane_result_type;

endpackage

// ===== rtl/dpsp_divider.sv =====
// ---------------------------------------------------------------------------
// dpsp_divider
// pipelined restoring divider, one quotient bit per stage, with sideband
// ---------------------------------------------------------------------------
module dpsp_divider #(
   parameter int NUM_W  = 36,
   parameter int DEN_W  = 24,
   parameter int Q_W    = 12,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_vld,
   input  logic [NUM_W-1:0]  num,
   input  logic [DEN_W-1:0]  den,
   input  logic [SIDE_W-1:0] side_in,
   output logic              out_vld,
   output logic [Q_W-1:0]    quo,
   output logic [SIDE_W-1:0] side_out
);

   localparam int CMP_W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

   logic [NUM_W-1:0]  rem_ff  [Q_W];
   logic [NUM_W-1:0]  rem_in  [Q_W];
   logic [DEN_W-1:0]  den_ff  [Q_W];
   logic [Q_W-1:0]    q_ff    [Q_W];
   logic [Q_W-1:0]    q_in    [Q_W];
   logic [SIDE_W-1:0] side_ff [Q_W];
   logic              vld_ff  [Q_W];

   logic [NUM_W-1:0]  src_rem  [Q_W];
   logic [DEN_W-1:0]  src_den  [Q_W];
   logic [Q_W-1:0]    src_q    [Q_W];
   logic [SIDE_W-1:0] src_side [Q_W];
   logic              src_vld  [Q_W];

   for (genvar i = 0; i < Q_W; i++) begin : g_stage
      localparam int B = Q_W - 1 - i;
      logic [CMP_W-1:0] shifted;
      logic             ge;

      if (i == 0) begin : g_first
         assign src_rem[i]  = num;
         assign src_den[i]  = den;
         assign src_q[i]    = '0;
         assign src_side[i] = side_in;
         assign src_vld[i]  = in_vld;
      end else begin : g_next
         assign src_rem[i]  = rem_ff[i-1];
         assign src_den[i]  = den_ff[i-1];
         assign src_q[i]    = q_ff[i-1];
         assign src_side[i] = side_ff[i-1];
         assign src_vld[i]  = vld_ff[i-1];
      end

      always_comb begin
         shifted   = CMP_W'(src_den[i]) << B;
         ge        = CMP_W'(src_rem[i]) >= shifted;
         rem_in[i] = ge ? NUM_W'(CMP_W'(src_rem[i]) - shifted) : src_rem[i];
         q_in[i]   = src_q[i] | (Q_W'(ge) << B);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (en) begin
            vld_ff[i] <= src_vld[i];
         end
         if (en) begin
            rem_ff[i]  <= rem_in[i];
            den_ff[i]  <= src_den[i];
            q_ff[i]    <= q_in[i];
            side_ff[i] <= src_side[i];
         end
      end
   end

   assign out_vld  = vld_ff[Q_W-1];
   assign quo      = q_ff[Q_W-1];
   assign side_out = side_ff[Q_W-1];

endmodule

// ===== rtl/dpsp_lane.sv =====
// ---------------------------------------------------------------------------
// dpsp_lane
// one sensor channel: code to millivolts, range check, span mapping
// ---------------------------------------------------------------------------
module dpsp_lane #(
   parameter int SAMPLE_BITS = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_vld,
   input  logic [SAMPLE_BITS-1:0]        raw,
   input  logic [SAMPLE_BITS-1:0]        vref,
   input  logic [dpsp_pkg::CAL_X_W-1:0]  cal_x_supply,
   input  dpsp_pkg::span_cfg_type        span_cfg,
   output logic                          out_vld,
   output dpsp_pkg::lane_result_type     result
);

   localparam int NUM1_W = dpsp_pkg::CAL_X_W + SAMPLE_BITS;
   localparam int DEN1_W = 2 * SAMPLE_BITS;
   localparam int SAT_W  = (NUM1_W > DEN1_W + dpsp_pkg::MV_W) ?
                           NUM1_W : DEN1_W + dpsp_pkg::MV_W;
   localparam int NUM2_W = dpsp_pkg::REG_W + dpsp_pkg::POS_W;

   // stage a: product and denominator
   logic [NUM1_W-1:0] prod_ff;
   logic [DEN1_W-1:0] den_ff;
   logic              bad_a_ff;
   logic              vld_a_ff;

   // stage b: saturation check
   logic [NUM1_W-1:0] num_b_ff;
   logic [DEN1_W-1:0] den_b_ff;
   logic              sat_b_ff;
   logic              bad_b_ff;
   logic              vld_b_ff;
   logic              sat_b_in;

   always_comb begin
      sat_b_in = SAT_W'(prod_ff) >= (SAT_W'(den_ff) << dpsp_pkg::MV_W);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
      end else if (en) begin
         vld_a_ff <= in_vld;
         vld_b_ff <= vld_a_ff;
      end
      if (en) begin
         prod_ff  <= NUM1_W'(cal_x_supply) * NUM1_W'(raw);
         den_ff   <= (DEN1_W'(vref) << SAMPLE_BITS) - DEN1_W'(vref);
         bad_a_ff <= (vref == '0);
         num_b_ff <= sat_b_in ? '0 : prod_ff;
         den_b_ff <= den_ff;
         sat_b_ff <= sat_b_in;
         bad_b_ff <= bad_a_ff;
      end
   end

   logic                      d1_vld;
   logic [dpsp_pkg::MV_W-1:0] d1_q;
   logic [1:0]                d1_side;

   dpsp_divider #(
      .NUM_W  (NUM1_W),
      .DEN_W  (DEN1_W),
      .Q_W    (dpsp_pkg::MV_W),
      .SIDE_W (2)
   ) u_conv_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (vld_b_ff),
      .num      (num_b_ff),
      .den      (den_b_ff),
      .side_in  ({sat_b_ff, bad_b_ff}),
      .out_vld  (d1_vld),
      .quo      (d1_q),
      .side_out (d1_side)
   );

   // stage m1: clamp into span, distance from low end
   logic [dpsp_pkg::MV_W-1:0]  mv;
   logic [dpsp_pkg::REG_W-1:0] lo;
   logic [dpsp_pkg::REG_W-1:0] hi;
   logic [dpsp_pkg::REG_W-1:0] clamped;
   logic [dpsp_pkg::REG_W-1:0] dist_in;
   logic [dpsp_pkg::REG_W-1:0] span_in;
   logic                       bad_m1_in;

   always_comb begin
      // anything at or above full scale reads as the top code
      mv      = d1_side[1] ? '1 : d1_q;
      lo      = (span_cfg.low < span_cfg.high) ? span_cfg.low : span_cfg.high;
      hi      = (span_cfg.low < span_cfg.high) ? span_cfg.high : span_cfg.low;
      clamped = (mv < lo) ? lo : (mv > hi) ? hi : mv;
      dist_in = (clamped > span_cfg.low) ? clamped - span_cfg.low
                                         : span_cfg.low - clamped;
      span_in = hi - lo;
      bad_m1_in = d1_side[0] || (span_in == '0) ||
                  (mv < dpsp_pkg::MV_W'(dpsp_pkg::RANGE_LOW_MV)) ||
                  (mv > dpsp_pkg::MV_W'(dpsp_pkg::RANGE_HIGH_MV));
   end

   logic [dpsp_pkg::REG_W-1:0] dist_ff;
   logic [dpsp_pkg::REG_W-1:0] span_ff;
   logic                       bad_m1_ff;
   logic                       vld_m1_ff;
   logic [NUM2_W-1:0]          scaled_ff;
   logic [dpsp_pkg::REG_W-1:0] span_m2_ff;
   logic                       bad_m2_ff;
   logic                       vld_m2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_m1_ff <= 1'b0;
         vld_m2_ff <= 1'b0;
      end else if (en) begin
         vld_m1_ff <= d1_vld;
         vld_m2_ff <= vld_m1_ff;
      end
      if (en) begin
         dist_ff    <= dist_in;
         span_ff    <= span_in;
         bad_m1_ff  <= bad_m1_in;
         scaled_ff  <= NUM2_W'(dist_ff) * NUM2_W'(dpsp_pkg::FULL_TRAVEL);
         span_m2_ff <= span_ff;
         bad_m2_ff  <= bad_m1_ff;
      end
   end

   logic [dpsp_pkg::POS_W-1:0] d2_q;
   logic                       d2_bad;

   dpsp_divider #(
      .NUM_W  (NUM2_W),
      .DEN_W  (dpsp_pkg::REG_W),
      .Q_W    (dpsp_pkg::POS_W),
      .SIDE_W (1)
   ) u_span_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (vld_m2_ff),
      .num      (scaled_ff),
      .den      (span_m2_ff),
      .side_in  (bad_m2_ff),
      .out_vld  (out_vld),
      .quo      (d2_q),
      .side_out (d2_bad)
   );

   assign result.bad = d2_bad;
   assign result.pos = d2_q;

endmodule

// ===== rtl/dpsp_merge.sv =====
// ---------------------------------------------------------------------------
// dpsp_merge
// channel agreement check and averaging, registered result
// ---------------------------------------------------------------------------
module dpsp_merge (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_vld,
   input  dpsp_pkg::lane_result_type  first,
   input  dpsp_pkg::lane_result_type  second,
   output logic                       out_vld,
   output logic [dpsp_pkg::POS_W-1:0] position,
   output logic                       implausible
);

   logic [dpsp_pkg::POS_W-1:0] diff;
   logic [dpsp_pkg::POS_W:0]   sum;
   logic                       bad_in;
   logic                       vld_ff;
   logic [dpsp_pkg::POS_W-1:0] pos_ff;
   logic                       bad_ff;

   always_comb begin
      diff   = (first.pos > second.pos) ? first.pos - second.pos
                                        : second.pos - first.pos;
      sum    = {1'b0, first.pos} + {1'b0, second.pos};
      bad_in = first.bad || second.bad ||
               (diff > dpsp_pkg::POS_W'(dpsp_pkg::MAX_DISAGREE));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= in_vld;
      end
      if (en) begin
         bad_ff <= bad_in;
         pos_ff <= bad_in ? '0 : sum[dpsp_pkg::POS_W:1];
      end
   end

   assign out_vld     = vld_ff;
   assign position    = pos_ff;
   assign implausible = bad_ff;

endmodule

// ===== rtl/dual_pedal_sensor_plausibility_core.sv =====
// throughput: one beat per cycle while not stalled; the two channel lanes
// and their pipelined dividers (12 and 14 stages) all advance together
// the pipeline holds while a finished rsp beat is stalled
// reset: synchronous, clears all valid flags and loads register defaults
// ---------------------------------------------------------------------------
// dual_pedal_sensor_plausibility_core
// redundant pedal sensor conversion and plausibility check, two lanes
// ---------------------------------------------------------------------------
`include "dual_pedal_sensor_plausibility_core_defines.svh"

module dual_pedal_sensor_plausibility_core #(
   parameter int SAMPLE_BITS = 12
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [SAMPLE_BITS-1:0]      req_first_sample,
   input  logic [SAMPLE_BITS-1:0]      req_second_sample,
   input  logic [SAMPLE_BITS-1:0]      req_reference_sample,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [dpsp_pkg::POS_W-1:0]  rsp_pedal_position,
   output logic                        rsp_implausible,
   input  logic                        csr_we,
   input  logic [dpsp_pkg::IDX_W-1:0]  csr_index,
   input  logic [dpsp_pkg::REG_W-1:0]  csr_wdata
);

   logic [dpsp_pkg::CAL_X_W-1:0] cal_x_supply_ff;
   logic [dpsp_pkg::CAL_X_W-1:0] cal_x_supply_in;
   dpsp_pkg::span_cfg_type       first_span_ff;
   dpsp_pkg::span_cfg_type       first_span_in;
   dpsp_pkg::span_cfg_type       second_span_ff;
   dpsp_pkg::span_cfg_type       second_span_in;

   // calibration is kept premultiplied by the supply voltage
   always_comb begin
      cal_x_supply_in = cal_x_supply_ff;
      first_span_in   = first_span_ff;
      second_span_in  = second_span_ff;
      if (csr_we) begin
         case (csr_index)
            dpsp_pkg::REG_REF_CAL: begin
               cal_x_supply_in = dpsp_pkg::CAL_X_W'(csr_wdata) *
                                 dpsp_pkg::CAL_X_W'(dpsp_pkg::SUPPLY_MV);
            end
            dpsp_pkg::REG_FIRST_LOW:   first_span_in.low   = csr_wdata;
            dpsp_pkg::REG_FIRST_HIGH:  first_span_in.high  = csr_wdata;
            dpsp_pkg::REG_SECOND_LOW:  second_span_in.low  = csr_wdata;
            dpsp_pkg::REG_SECOND_HIGH: second_span_in.high = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_x_supply_ff <= dpsp_pkg::CAL_X_W'(dpsp_pkg::RST_REF_CAL) *
                            dpsp_pkg::CAL_X_W'(dpsp_pkg::SUPPLY_MV);
         first_span_ff   <= '{low: dpsp_pkg::RST_SPAN_LOW, high: dpsp_pkg::RST_SPAN_HIGH};
         second_span_ff  <= '{low: dpsp_pkg::RST_SPAN_LOW, high: dpsp_pkg::RST_SPAN_HIGH};
      end else begin
         cal_x_supply_ff <= cal_x_supply_in;
         first_span_ff   <= first_span_in;
         second_span_ff  <= second_span_in;
      end
   end

   // whole pipeline moves when the output slot is free or being taken
   logic advance;
   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;

   logic                      accept;
   logic                      first_vld;
   logic                      second_vld;
   dpsp_pkg::lane_result_type first_res;
   dpsp_pkg::lane_result_type second_res;

   assign accept = req_valid && advance;

   dpsp_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_first_lane (
      .clock        (clock),
      .reset        (reset),
      .en           (advance),
      .in_vld       (accept),
      .raw          (req_first_sample),
      .vref         (req_reference_sample),
      .cal_x_supply (cal_x_supply_ff),
      .span_cfg     (first_span_ff),
      .out_vld      (first_vld),
      .result       (first_res)
   );

   dpsp_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_second_lane (
      .clock        (clock),
      .reset        (reset),
      .en           (advance),
      .in_vld       (accept),
      .raw          (req_second_sample),
      .vref         (req_reference_sample),
      .cal_x_supply (cal_x_supply_ff),
      .span_cfg     (second_span_ff),
      .out_vld      (second_vld),
      .result       (second_res)
   );

   dpsp_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .en          (advance),
      .in_vld      (first_vld),
      .first       (first_res),
      .second      (second_res),
      .out_vld     (rsp_valid),
      .position    (rsp_pedal_position),
      .implausible (rsp_implausible)
   );

   `DPSP_ASSERT_NOW(a_bad_zero, clock, reset, rsp_valid && rsp_implausible, rsp_pedal_position == '0)
   `DPSP_ASSERT_NOW(a_pos_max, clock, reset, rsp_valid && !rsp_implausible, rsp_pedal_position <= 14'd10000)
   `DPSP_ASSERT_NOW(a_lanes_lock, clock, reset, 1'b1, first_vld == second_vld)
   `DPSP_ASSERT_NOW(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)

endmodule

// ===== verif/tb_dual_pedal_sensor_plausibility_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_dual_pedal_sensor_plausibility_core
// drives sensor sample beats through the plausibility core under several
// calibration settings and random stalls on both sides, predicts each
// position and flag in a scoreboard and compares every rsp beat in order
// ---------------------------------------------------------------------------
module tb_dual_pedal_sensor_plausibility_core;

   localparam int SB = 12;
   localparam int FULL = (1 << SB) - 1;

   class pedal_scoreboard;
      typedef struct {
         logic [dpsp_pkg::POS_W-1:0] pos;
         logic                       bad;
      } pedal_result_type;

      pedal_result_type expected_q[$];
      int unsigned      cal, first_lo, first_hi, second_lo, second_hi;
      int               errors;

      function new();
         cal = 32'(dpsp_pkg::RST_REF_CAL);
         first_lo = 32'(dpsp_pkg::RST_SPAN_LOW);
         first_hi = 32'(dpsp_pkg::RST_SPAN_HIGH);
         second_lo = 32'(dpsp_pkg::RST_SPAN_LOW);
         second_hi = 32'(dpsp_pkg::RST_SPAN_HIGH);
         errors = 0;
      endfunction

      function void set_reg(logic [dpsp_pkg::IDX_W-1:0] idx,
                            logic [dpsp_pkg::REG_W-1:0] val);
         case (idx)
            dpsp_pkg::REG_REF_CAL:     cal = 32'(val);
            dpsp_pkg::REG_FIRST_LOW:   first_lo = 32'(val);
            dpsp_pkg::REG_FIRST_HIGH:  first_hi = 32'(val);
            dpsp_pkg::REG_SECOND_LOW:  second_lo = 32'(val);
            dpsp_pkg::REG_SECOND_HIGH: second_hi = 32'(val);
            default: ;
         endcase
      endfunction

      function longint unsigned sensor_mv(longint unsigned raw, longint unsigned vref);
         return (longint'(dpsp_pkg::SUPPLY_MV) * cal * raw) / (vref * FULL);
      endfunction

      // position of mv within the span, reversed spans count from low toward high
      function longint unsigned span_position(longint unsigned mv, longint unsigned lo_mv,
                                               longint unsigned hi_mv, ref bit bad);
         longint unsigned lo, hi, v, offset;
         lo = (lo_mv < hi_mv) ? lo_mv : hi_mv;
         hi = (lo_mv < hi_mv) ? hi_mv : lo_mv;
         v = (mv < lo) ? lo : (mv > hi) ? hi : mv;
         offset = (v > lo_mv) ? v - lo_mv : lo_mv - v;
         if (hi == lo) begin
            bad = 1;
            return 0;
         end
         return offset * dpsp_pkg::FULL_TRAVEL / (hi - lo);
      endfunction

      function void note_sample(logic [SB-1:0] raw1, logic [SB-1:0] raw2,
                                logic [SB-1:0] vref);
         pedal_result_type r;
         bit bad;
         longint unsigned mv1, mv2, p1, p2, diff;
         bad = 0;
         r.pos = 0;
         if (vref == 0) begin
            bad = 1;
         end else begin
            mv1 = sensor_mv(raw1, vref);
            mv2 = sensor_mv(raw2, vref);
            if (mv1 < dpsp_pkg::RANGE_LOW_MV || mv1 > dpsp_pkg::RANGE_HIGH_MV ||
                mv2 < dpsp_pkg::RANGE_LOW_MV || mv2 > dpsp_pkg::RANGE_HIGH_MV) bad = 1;
            p1 = span_position(mv1, first_lo, first_hi, bad);
            p2 = span_position(mv2, second_lo, second_hi, bad);
            diff = (p1 > p2) ? p1 - p2 : p2 - p1;
            if (diff > dpsp_pkg::MAX_DISAGREE) bad = 1;
            if (!bad) r.pos = dpsp_pkg::POS_W'((p1 + p2) / 2);
         end
         r.bad = bad;
         expected_q.push_back(r);
      endfunction

      function void check_result(logic [dpsp_pkg::POS_W-1:0] pos, logic bad);
         pedal_result_type e;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected rsp beat pos %0d implausible %0b", $time, pos, bad);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         if (pos !== e.pos) begin
            $display("%0t: pedal_position expected %0d actual %0d", $time, e.pos, pos);
            errors++;
         end
         if (bad !== e.bad) begin
            $display("%0t: implausible expected %0b actual %0b", $time, e.bad, bad);
            errors++;
         end
      endfunction
   endclass

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic [SB-1:0]              req_first_sample;
   logic [SB-1:0]              req_second_sample;
   logic [SB-1:0]              req_reference_sample;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic [dpsp_pkg::POS_W-1:0] rsp_pedal_position;
   logic                       rsp_implausible;
   logic                       csr_we;
   logic [dpsp_pkg::IDX_W-1:0] csr_index;
   logic [dpsp_pkg::REG_W-1:0] csr_wdata;

   pedal_scoreboard sb = new();
   int  send_idle_pct;
   int  recv_idle_pct;
   int  hold_left;
   bit  start_long_hold;

   dual_pedal_sensor_plausibility_core #(.SAMPLE_BITS(SB)) dut (.*);

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // receiver stalls, with one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
      end else if (start_long_hold) begin
         start_long_hold = 0;
         hold_left = 300;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_sample(req_first_sample, req_second_sample, req_reference_sample);
         if (rsp_valid && !rsp_stall)
            sb.check_result(rsp_pedal_position, rsp_implausible);
      end
   end

   task automatic send_sample(input logic [SB-1:0] raw1, input logic [SB-1:0] raw2,
                              input logic [SB-1:0] vref);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_first_sample <= raw1;
      req_second_sample <= raw2;
      req_reference_sample <= vref;
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(input logic [dpsp_pkg::IDX_W-1:0] idx,
                            input logic [dpsp_pkg::REG_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_reg(idx, val);
      @(posedge clock);
   endtask

   task automatic write_config(input int unsigned cal, input int unsigned f_lo,
                               input int unsigned f_hi, input int unsigned s_lo,
                               input int unsigned s_hi);
      write_reg(dpsp_pkg::REG_REF_CAL, dpsp_pkg::REG_W'(cal));
      write_reg(dpsp_pkg::REG_FIRST_LOW, dpsp_pkg::REG_W'(f_lo));
      write_reg(dpsp_pkg::REG_FIRST_HIGH, dpsp_pkg::REG_W'(f_hi));
      write_reg(dpsp_pkg::REG_SECOND_LOW, dpsp_pkg::REG_W'(s_lo));
      write_reg(dpsp_pkg::REG_SECOND_HIGH, dpsp_pkg::REG_W'(s_hi));
   endtask

   // mostly codes that land near the valid window with close channels
   task automatic random_sample();
      longint unsigned vref, mv, raw1, raw2, c;
      int d;
      c = (sb.cal == 0) ? 1 : sb.cal;
      if ($urandom_range(99) < 25) begin
         send_sample(SB'($urandom_range(FULL)), SB'($urandom_range(FULL)),
                     ($urandom_range(19) == 0) ? SB'(0) : SB'($urandom_range(FULL)));
         return;
      end
      vref = $urandom_range(c * 8 / 10 + 1, c * 12 / 10 + 1);
      if (vref > FULL) vref = FULL;
      mv = $urandom_range(600, 2800);
      raw1 = mv * vref * FULL / (dpsp_pkg::SUPPLY_MV * c);
      d = $urandom_range(0, 600) - 300;
      mv = ((int'(mv) + d) < 0) ? 0 : mv + d;
      raw2 = mv * vref * FULL / (dpsp_pkg::SUPPLY_MV * c);
      if (raw1 > FULL) raw1 = FULL;
      if (raw2 > FULL) raw2 = FULL;
      send_sample(SB'(raw1), SB'(raw2), SB'(vref));
   endtask

   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_first_sample = '0;
      req_second_sample = '0;
      req_reference_sample = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      start_long_hold = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, register defaults
      send_sample(956, 956, 1655);     // exactly at the low range edge
      send_sample(3686, 3686, 1655);   // exactly at the high range edge
      send_sample(955, 955, 1655);     // just below range
      send_sample(3687, 3687, 1655);   // just above range
      send_sample(956, 3686, 1655);    // channels disagree
      send_sample(2000, 2100, 1655);
      send_sample(2000, 2000, 0);      // zero reference code
      send_sample(0, 0, 1655);
      send_sample(FULL, FULL, FULL);
      send_sample(FULL, FULL, 1);
      send_sample(0, FULL, FULL);
      send_sample(2500, 2450, 1600);
      wait_drained();

      // ignored register indexes must not disturb anything
      write_reg(3'd5, 12'hFFF);
      write_reg(3'd6, 12'h000);
      write_reg(3'd7, 12'hAAA);
      send_sample(2000, 2050, 1655);
      send_sample(1500, 1480, 1700);
      wait_drained();

      for (int ph = 0; ph < 7; ph++) begin
         case (ph)
            0: write_config(1655, 700, 2700, 700, 2700);
            1: write_config(4095, 0, 3300, 0, 3300);
            2: write_config(1, 3300, 0, 2700, 700);      // reversed spans
            3: write_config(1655, 1500, 1500, 700, 2700); // zero span
            4: write_config(0, 700, 2700, 700, 2700);     // zero calibration
            5: write_config(2730, 900, 2400, 2500, 1000);
            default: write_config($urandom_range(1, FULL), $urandom_range(0, 1500),
                                  $urandom_range(1600, 3300), $urandom_range(0, 1500),
                                  $urandom_range(1600, 3300));
         endcase
         case (ph % 3)
            0: begin send_idle_pct = 6; recv_idle_pct = 68; end
            1: begin send_idle_pct = 68; recv_idle_pct = 6; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         if (ph == 2) start_long_hold = 1;
         repeat (120) random_sample();
         wait_drained();
      end

      if (sb.errors == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/dpsp_pkg.sv
rtl/dpsp_divider.sv
rtl/dpsp_lane.sv
rtl/dpsp_merge.sv
rtl/dual_pedal_sensor_plausibility_core.sv
verif/tb_dual_pedal_sensor_plausibility_core.sv
